// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define ASSERT_IMPL(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication, sampled on clk, off while arst_n is low
`define ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/dtem_pkg.sv =====
// shared types and constants of the dual thermocouple monitor
package dtem_pkg;

	localparam int ADC_W    = 12;
	localparam int GAIN_W   = 20;
	localparam int WEIGHT_W = 17;
	localparam int OFS_W    = 13;
	localparam int TEMP_W   = 16;
	localparam int FILT_W   = 32;
	localparam int FRAC_W   = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;

	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(65536);

	localparam logic signed [FILT_W-1:0] FILT_MAX = {1'b0, {(FILT_W-1){1'b1}}};
	localparam logic signed [FILT_W-1:0] FILT_MIN = {1'b1, {(FILT_W-1){1'b0}}};
	localparam logic signed [TEMP_W-1:0] TEMP_MAX = {1'b0, {(TEMP_W-1){1'b1}}};
	localparam logic signed [TEMP_W-1:0] TEMP_MIN = {1'b1, {(TEMP_W-1){1'b0}}};

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_GAIN   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EMA_WEIGHT   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_A     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_B     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FAULT_FLOOR  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SPREAD_LIMIT = 3'd5;

	localparam logic [GAIN_W-1:0]   RST_SCALE_GAIN   = GAIN_W'(209715);
	localparam logic [WEIGHT_W-1:0] RST_EMA_WEIGHT   = WEIGHT_W'(9830);
	localparam logic signed [TEMP_W-1:0] RST_FAULT_FLOOR = -16'sd160;
	localparam logic [TEMP_W-1:0]   RST_SPREAD_LIMIT = TEMP_W'(800);

	// stage enables from the sequencer to each lane
	typedef struct packed {
		logic start;
		logic load;
		logic adv2;
		logic adv3;
		logic adv4;
		logic adv5;
	} lane_ctl_t;

endpackage

// ===== rtl/dual_thermocouple_ema_monitor.sv =====
// top level of the dual thermocouple monitor: registers, sequencer, two lanes, merge
//
// channel   signals                                                      direction
// input     in_valid, in_ready, raw_a, raw_b, restart_filter             in
// output    out_valid, out_ready, temp_a, temp_b, average, spread, fault out
// config    cfg_valid, cfg_ready, cfg_index, cfg_data                    in
//
// an accepted word runs five stages per lane (scale multiply, difference,
// weight multiply, filter update, offset and saturation), then the merge
// stage loads the output register; in_ready drops for the five lane stages;
// the result waits in the output register and the next word can already
// enter while it waits
// reset sets registers to their defaults, clears the filters and the primed flag
module dual_thermocouple_ema_monitor (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [dtem_pkg::ADC_W-1:0]   raw_a,
	input  logic signed [dtem_pkg::ADC_W-1:0]   raw_b,
	input  logic                                restart_filter,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [dtem_pkg::TEMP_W-1:0]  temp_a,
	output logic signed [dtem_pkg::TEMP_W-1:0]  temp_b,
	output logic signed [dtem_pkg::TEMP_W-1:0]  average,
	output logic [dtem_pkg::TEMP_W-1:0]         spread,
	output logic                                fault,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [dtem_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [dtem_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import dtem_pkg::*;

	logic [GAIN_W-1:0]          scale_gain_q;
	logic [WEIGHT_W-1:0]        ema_weight_q;
	logic signed [OFS_W-1:0]    offset_a_q;
	logic signed [OFS_W-1:0]    offset_b_q;
	logic signed [TEMP_W-1:0]   fault_floor_q;
	logic [TEMP_W-1:0]          spread_limit_q;

	logic        primed_q;
	logic        v_s1, v_s2, v_s3, v_s4, v_s5;
	logic        out_valid_q;
	logic        start;
	logic        take;
	lane_ctl_t   ctl;

	logic signed [TEMP_W-1:0] ta, tb;
	logic                     below_a, below_b;

	assign cfg_ready = 1'b1;
	assign in_ready  = !(v_s1 | v_s2 | v_s3 | v_s4 | v_s5);
	assign start     = in_valid & in_ready;
	assign take      = v_s5 & (!out_valid_q | out_ready);
	assign out_valid = out_valid_q;

	assign ctl.start = start;
	assign ctl.load  = restart_filter | !primed_q;
	assign ctl.adv2  = v_s1;
	assign ctl.adv3  = v_s2;
	assign ctl.adv4  = v_s3;
	assign ctl.adv5  = v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_gain_q   <= RST_SCALE_GAIN;
			ema_weight_q   <= RST_EMA_WEIGHT;
			offset_a_q     <= '0;
			offset_b_q     <= '0;
			fault_floor_q  <= RST_FAULT_FLOOR;
			spread_limit_q <= RST_SPREAD_LIMIT;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_SCALE_GAIN:   scale_gain_q   <= cfg_data[GAIN_W-1:0];
				CFG_EMA_WEIGHT:   ema_weight_q   <= cfg_data[WEIGHT_W-1:0];
				CFG_OFFSET_A:     offset_a_q     <= cfg_data[OFS_W-1:0];
				CFG_OFFSET_B:     offset_b_q     <= cfg_data[OFS_W-1:0];
				CFG_FAULT_FLOOR:  fault_floor_q  <= cfg_data[TEMP_W-1:0];
				CFG_SPREAD_LIMIT: spread_limit_q <= cfg_data[TEMP_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q    <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (start) begin
				primed_q <= 1'b1;
			end
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			// last lane stage holds until the output register is free
			v_s5 <= v_s4 | (v_s5 & !take);
			if (take) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	dtem_lane u_lane_a (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.raw       (raw_a),
		.gain      (scale_gain_q),
		.weight    (ema_weight_q),
		.offset    (offset_a_q),
		.floor_lim (fault_floor_q),
		.temp      (ta),
		.below     (below_a)
	);

	dtem_lane u_lane_b (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.raw       (raw_b),
		.gain      (scale_gain_q),
		.weight    (ema_weight_q),
		.offset    (offset_b_q),
		.floor_lim (fault_floor_q),
		.temp      (tb),
		.below     (below_b)
	);

	dtem_merge u_merge (
		.clk     (clk),
		.take    (take),
		.ta      (ta),
		.tb      (tb),
		.below_a (below_a),
		.below_b (below_b),
		.limit   (spread_limit_q),
		.temp_a  (temp_a),
		.temp_b  (temp_b),
		.average (average),
		.spread  (spread),
		.fault   (fault)
	);

endmodule

// ===== rtl/dtem_lane.sv =====
// one channel: scaling, exponential moving average filter, offset and saturation
module dtem_lane (
	input  logic                                clk,
	input  logic                                arst_n,
	input  dtem_pkg::lane_ctl_t                 ctl,
	input  logic signed [dtem_pkg::ADC_W-1:0]   raw,
	input  logic [dtem_pkg::GAIN_W-1:0]         gain,
	input  logic [dtem_pkg::WEIGHT_W-1:0]       weight,
	input  logic signed [dtem_pkg::OFS_W-1:0]   offset,
	input  logic signed [dtem_pkg::TEMP_W-1:0]  floor_lim,
	output logic signed [dtem_pkg::TEMP_W-1:0]  temp,
	output logic                                below
);
	import dtem_pkg::*;

	logic signed [ADC_W+GAIN_W:0]       prod_s1;
	logic                               load_s1, load_s2, load_s3;
	logic signed [TEMP_W-1:0]           x_s2, x_s3;
	logic signed [FILT_W:0]             diff_s2;
	logic signed [FILT_W+WEIGHT_W+1:0]  m_s3;
	logic                               below_s3;
	logic signed [FILT_W-1:0]           filter_q;
	logic signed [TEMP_W-1:0]           temp_q;

	logic [WEIGHT_W-1:0]                w_eff;
	logic signed [FILT_W+3:0]           upd_sum;
	logic signed [FILT_W-1:0]           filt_nxt;
	logic signed [TEMP_W:0]             t_sum;

	assign w_eff = (weight > WEIGHT_ONE) ? WEIGHT_ONE : weight;

	// filter plus weighted step, floor of the product shift
	assign upd_sum = (FILT_W+4)'(filter_q) + (FILT_W+4)'(m_s3 >>> FRAC_W);

	always_comb begin
		if (load_s3) begin
			filt_nxt = {x_s3, {FRAC_W{1'b0}}};
		end else if (upd_sum > (FILT_W+4)'(FILT_MAX)) begin
			filt_nxt = FILT_MAX;
		end else if (upd_sum < (FILT_W+4)'(FILT_MIN)) begin
			filt_nxt = FILT_MIN;
		end else begin
			filt_nxt = upd_sum[FILT_W-1:0];
		end
	end

	assign t_sum = (TEMP_W+1)'($signed(filter_q[FILT_W-1:FRAC_W])) + (TEMP_W+1)'(offset);

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			prod_s1 <= raw * $signed({1'b0, gain});
			load_s1 <= ctl.load;
		end
		if (ctl.adv2) begin
			x_s2    <= prod_s1[FRAC_W+TEMP_W-1:FRAC_W];
			diff_s2 <= (FILT_W+1)'($signed({prod_s1[FRAC_W+TEMP_W-1:FRAC_W], {FRAC_W{1'b0}}}))
				- (FILT_W+1)'(filter_q);
			load_s2 <= load_s1;
		end
		if (ctl.adv3) begin
			m_s3     <= diff_s2 * $signed({1'b0, w_eff});
			x_s3     <= x_s2;
			below_s3 <= x_s2 < floor_lim;
			load_s3  <= load_s2;
		end
		if (ctl.adv5) begin
			if (t_sum > (TEMP_W+1)'(TEMP_MAX)) begin
				temp_q <= TEMP_MAX;
			end else if (t_sum < (TEMP_W+1)'(TEMP_MIN)) begin
				temp_q <= TEMP_MIN;
			end else begin
				temp_q <= t_sum[TEMP_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_q <= '0;
		end else if (ctl.adv4) begin
			filter_q <= filt_nxt;
		end
	end

	assign temp  = temp_q;
	assign below = below_s3;

endmodule

// ===== rtl/dtem_merge.sv =====
// combines both lanes into the registered output word
module dtem_merge (
	input  logic                                clk,
	input  logic                                take,
	input  logic signed [dtem_pkg::TEMP_W-1:0]  ta,
	input  logic signed [dtem_pkg::TEMP_W-1:0]  tb,
	input  logic                                below_a,
	input  logic                                below_b,
	input  logic [dtem_pkg::TEMP_W-1:0]         limit,
	output logic signed [dtem_pkg::TEMP_W-1:0]  temp_a,
	output logic signed [dtem_pkg::TEMP_W-1:0]  temp_b,
	output logic signed [dtem_pkg::TEMP_W-1:0]  average,
	output logic [dtem_pkg::TEMP_W-1:0]         spread,
	output logic                                fault
);
	import dtem_pkg::*;

	logic signed [TEMP_W:0] sum;
	logic signed [TEMP_W:0] diff;
	logic [TEMP_W-1:0]      mag;

	assign sum  = (TEMP_W+1)'(ta) + (TEMP_W+1)'(tb);
	assign diff = (TEMP_W+1)'(ta) - (TEMP_W+1)'(tb);
	assign mag  = diff[TEMP_W] ? TEMP_W'(-diff) : diff[TEMP_W-1:0];

	always_ff @(posedge clk) begin
		if (take) begin
			temp_a  <= ta;
			temp_b  <= tb;
			average <= sum[TEMP_W:1];
			spread  <= mag;
			fault   <= below_a | below_b | (mag > limit);
		end
	end

endmodule

// ===== rtl/dtem_checker.sv =====
// port-level checks of the dual thermocouple monitor, bound to the top level
`include "assert_macros.svh"

module dtem_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_ready,
	input  logic                                out_valid,
	input  logic                                out_ready,
	input  logic signed [dtem_pkg::TEMP_W-1:0]  temp_a,
	input  logic signed [dtem_pkg::TEMP_W-1:0]  temp_b,
	input  logic signed [dtem_pkg::TEMP_W-1:0]  average,
	input  logic [dtem_pkg::TEMP_W-1:0]         spread,
	input  logic                                fault,
	input  logic                                cfg_valid,
	input  logic                                cfg_ready,
	input  logic [dtem_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [dtem_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import dtem_pkg::*;

	logic signed [TEMP_W:0] pair_sum;
	logic signed [TEMP_W:0] pair_diff;
	logic [TEMP_W-1:0]      limit_q;

	assign pair_sum  = (TEMP_W+1)'(temp_a) + (TEMP_W+1)'(temp_b);
	assign pair_diff = (TEMP_W+1)'(temp_a) - (TEMP_W+1)'(temp_b);

	// shadow of the spread limit as seen on the configuration port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= RST_SPREAD_LIMIT;
		end else if (cfg_valid && cfg_ready && cfg_index == CFG_SPREAD_LIMIT) begin
			limit_q <= cfg_data[TEMP_W-1:0];
		end
	end

	// one word at a time through the lanes
	`ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

	// a waiting result stays valid and keeps its average
	`ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(average))

	`ASSERT_IMPL(a_average, out_valid, average == pair_sum[TEMP_W:1])

	`ASSERT_IMPL(a_spread, out_valid,
		(pair_diff[TEMP_W] ? TEMP_W'(-pair_diff) : pair_diff[TEMP_W-1:0]) == spread)

	`ASSERT_IMPL(a_fault_on_spread, out_valid && (spread > limit_q), fault)

endmodule

bind dual_thermocouple_ema_monitor dtem_checker u_dtem_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.temp_a    (temp_a),
	.temp_b    (temp_b),
	.average   (average),
	.spread    (spread),
	.fault     (fault),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready),
	.cfg_index (cfg_index),
	.cfg_data  (cfg_data)
);

// ===== bench/tb_top.sv =====
// self-checking bench for the dual thermocouple monitor: driver tasks, filter predictor, checks
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import dtem_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_7 = 3'd7;
	localparam int RANDOM_PHASES    = 8;
	localparam int PHASE_SAMPLES    = 250;
	localparam int DRAIN_LIMIT      = 10000;
	localparam int MAX_REPORT_LINES = 50;

	typedef struct packed {
		logic signed [TEMP_W-1:0] t_a;
		logic signed [TEMP_W-1:0] t_b;
		logic signed [TEMP_W-1:0] avg;
		logic [TEMP_W-1:0]        spr;
		logic                     flt;
	} reading_t;

	// keeps its own copy of the registers and both filters, queues the reading each word should give
	class temp_scoreboard;
		longint gain, weight, ofs_a, ofs_b, floor_t, limit;
		longint filt_a, filt_b;
		bit primed;
		reading_t expected_q[$];
		int mismatches, n_samples, n_restarts, n_checked, n_faults, n_saturated, n_writes;

		function new();
			gain = RST_SCALE_GAIN;
			weight = RST_EMA_WEIGHT;
			ofs_a = 0;
			ofs_b = 0;
			floor_t = longint'(RST_FAULT_FLOOR);
			limit = RST_SPREAD_LIMIT;
			filt_a = 0;
			filt_b = 0;
			primed = 1'b0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function longint clamp(longint v, longint lo, longint hi);
			return (v < lo) ? lo : ((v > hi) ? hi : v);
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			n_writes++;
			case (idx)
				CFG_SCALE_GAIN:   gain = longint'(data[GAIN_W-1:0]);
				CFG_EMA_WEIGHT:   weight = longint'(data[WEIGHT_W-1:0]);
				CFG_OFFSET_A:     ofs_a = longint'(signed'(data[OFS_W-1:0]));
				CFG_OFFSET_B:     ofs_b = longint'(signed'(data[OFS_W-1:0]));
				CFG_FAULT_FLOOR:  floor_t = longint'(signed'(data[TEMP_W-1:0]));
				CFG_SPREAD_LIMIT: limit = longint'(data[TEMP_W-1:0]);
				default: ;
			endcase
		endfunction

		function longint to_temp(logic signed [ADC_W-1:0] raw);
			return (longint'(raw) * gain) >>> 16;
		endfunction

		function longint filter_step(longint filt, longint x, bit load);
			longint xf, w, v;
			xf = x <<< FRAC_W;
			// weights past one behave as one
			w = (weight > longint'(WEIGHT_ONE)) ? longint'(WEIGHT_ONE) : weight;
			if (load)
				v = xf;
			else
				v = filt + ((w * (xf - filt)) >>> 16);
			return clamp(v, longint'(FILT_MIN), longint'(FILT_MAX));
		endfunction

		function void note_input(logic signed [ADC_W-1:0] a, logic signed [ADC_W-1:0] b,
				logic restart);
			longint xa, xb, ta_raw, tb_raw, ta, tb, spr;
			bit load;
			reading_t want;
			xa = to_temp(a);
			xb = to_temp(b);
			load = !primed || restart;
			filt_a = filter_step(filt_a, xa, load);
			filt_b = filter_step(filt_b, xb, load);
			primed = 1'b1;
			ta_raw = (filt_a >>> FRAC_W) + ofs_a;
			tb_raw = (filt_b >>> FRAC_W) + ofs_b;
			ta = clamp(ta_raw, longint'(TEMP_MIN), longint'(TEMP_MAX));
			tb = clamp(tb_raw, longint'(TEMP_MIN), longint'(TEMP_MAX));
			spr = (ta >= tb) ? ta - tb : tb - ta;
			want.t_a = ta[TEMP_W-1:0];
			want.t_b = tb[TEMP_W-1:0];
			want.avg = TEMP_W'((ta + tb) >>> 1);
			want.spr = spr[TEMP_W-1:0];
			// floor compare is on the unfiltered value, before the offset
			want.flt = (xa < floor_t) || (xb < floor_t) || (spr > limit);
			expected_q.push_back(want);
			n_samples++;
			if (restart)
				n_restarts++;
			if (want.flt)
				n_faults++;
			if (ta != ta_raw || tb != tb_raw)
				n_saturated++;
		endfunction

		task report_mismatch(string what, logic [TEMP_W-1:0] got, logic [TEMP_W-1:0] want);
			mismatches++;
			if (mismatches <= MAX_REPORT_LINES)
				$display("mismatch at result %0d: %s, got %h, wanted %h", n_checked, what,
					got, want);
		endtask

		task check_result(reading_t got);
			reading_t want;
			n_checked++;
			if (expected_q.size() == 0) begin
				report_mismatch("result with no word waiting", '0, '0);
				return;
			end
			want = expected_q.pop_front();
			if (got.t_a !== want.t_a)
				report_mismatch("temp_a", got.t_a, want.t_a);
			if (got.t_b !== want.t_b)
				report_mismatch("temp_b", got.t_b, want.t_b);
			if (got.avg !== want.avg)
				report_mismatch("average", got.avg, want.avg);
			if (got.spr !== want.spr)
				report_mismatch("spread", got.spr, want.spr);
			if (got.flt !== want.flt)
				report_mismatch("fault", {15'd0, got.flt}, {15'd0, want.flt});
		endtask

		task check_leftovers();
			while (expected_q.size() != 0) begin
				void'(expected_q.pop_front());
				report_mismatch("word never produced a result", '0, '0);
			end
		endtask
	endclass

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        in_valid = 1'b0;
	logic                        in_ready;
	logic signed [ADC_W-1:0]     raw_a = '0;
	logic signed [ADC_W-1:0]     raw_b = '0;
	logic                        restart_filter = 1'b0;
	logic                        out_valid;
	logic                        out_ready = 1'b0;
	logic signed [TEMP_W-1:0]    temp_a;
	logic signed [TEMP_W-1:0]    temp_b;
	logic signed [TEMP_W-1:0]    average;
	logic [TEMP_W-1:0]           spread;
	logic                        fault;
	logic                        cfg_valid = 1'b0;
	logic                        cfg_ready;
	logic [CFG_IDX_W-1:0]        cfg_index = '0;
	logic [CFG_DATA_W-1:0]       cfg_data = '0;

	temp_scoreboard sb = new();
	bit idle_on = 1'b1;
	bit quiet = 1'b0;
	int n_settings;

	dual_thermocouple_ema_monitor i_dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
			if (in_valid && in_ready)
				sb.note_input(raw_a, raw_b, restart_filter);
			if (out_valid && out_ready)
				sb.check_result({temp_a, temp_b, average, spread, fault});
		end
	end

	// receiver back-pressure in bursts
	always begin
		@(posedge clk);
		if (arst_n && idle_on && !quiet && $urandom_range(0, 4) == 0) begin
			out_ready <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			out_ready <= 1'b1;
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic send_sample(input logic signed [ADC_W-1:0] a, input logic signed [ADC_W-1:0] b,
			input logic rs);
		in_valid <= 1'b1;
		raw_a <= a;
		raw_b <= b;
		restart_filter <= rs;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (idle_on && !quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// let every queued word come out before touching the registers
	task automatic settle();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending() != 0);
	endtask

	// bits above the register width are random, the block must ignore them
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val, input int width);
		logic [CFG_DATA_W-1:0] mask, data;
		mask = (CFG_DATA_W'(1) << width) - 1'b1;
		data = (CFG_DATA_W'($urandom) & ~mask) | (CFG_DATA_W'(val) & mask);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic write_all(input int gain, input int weight, input int oa, input int ob,
			input int fl, input int lim);
		write_reg(CFG_SCALE_GAIN, gain, GAIN_W);
		write_reg(CFG_EMA_WEIGHT, weight, WEIGHT_W);
		write_reg(CFG_OFFSET_A, oa, OFS_W);
		write_reg(CFG_OFFSET_B, ob, OFS_W);
		write_reg(CFG_FAULT_FLOOR, fl, TEMP_W);
		write_reg(CFG_SPREAD_LIMIT, lim, TEMP_W);
		if ($urandom_range(0, 1))
			write_reg($urandom_range(0, 1) ? CFG_UNMAPPED_6 : CFG_UNMAPPED_7, $urandom, CFG_DATA_W);
		cfg_valid <= 1'b0;
		n_settings++;
	endtask

	function automatic int pick_offset();
		case ($urandom_range(0, 4))
			0: return -4096;
			1: return 4095;
			default: return int'($urandom_range(0, 800)) - 400;
		endcase
	endfunction

	task automatic random_settings();
		int gain, weight, fl, lim;
		case ($urandom_range(0, 5))
			0: gain = 0;
			1: gain = 1048575;
			2: gain = $urandom_range(0, 1048575);
			default: gain = $urandom_range(100000, 400000);
		endcase
		case ($urandom_range(0, 6))
			0: weight = 0;
			1: weight = 65536;
			2: weight = $urandom_range(65537, 131071);
			3: weight = 1;
			default: weight = $urandom_range(1, 65536);
		endcase
		case ($urandom_range(0, 4))
			0: fl = -32768;
			1: fl = 32767;
			default: fl = int'($urandom_range(0, 4000)) - 2000;
		endcase
		case ($urandom_range(0, 4))
			0: lim = 0;
			1: lim = 65535;
			default: lim = $urandom_range(0, 3000);
		endcase
		write_all(gain, weight, pick_offset(), pick_offset(), fl, lim);
	endtask

	// mostly slow drift like a real sensor, with jumps and rail values mixed in
	function automatic logic signed [ADC_W-1:0] next_raw(logic signed [ADC_W-1:0] prev);
		int v;
		case ($urandom_range(0, 9))
			0: v = $urandom_range(0, 1) ? 2047 : -2048;
			1, 2: v = int'($urandom_range(0, 4095)) - 2048;
			default: v = int'(prev) + int'($urandom_range(0, 40)) - 20;
		endcase
		if (v > 2047)
			v = 2047;
		if (v < -2048)
			v = -2048;
		return v[ADC_W-1:0];
	endfunction

	task automatic random_phase(input int n);
		logic signed [ADC_W-1:0] a, b;
		a = next_raw('0);
		b = a;
		for (int i = 0; i < n; i++) begin
			a = next_raw(a);
			b = next_raw(b);
			send_sample(a, b, $urandom_range(0, 19) == 0);
		end
	endtask

	initial begin
		int waited;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings; the first word loads the filters
		send_sample(12'sd100, -12'sd50, 1'b0);
		send_sample(12'sd2047, -12'sd2048, 1'b0);
		send_sample(-12'sd1, 12'sd0, 1'b0);
		send_sample(12'sd0, -12'sd1, 1'b1);
		send_sample(-12'sd2048, 12'sd2047, 1'b1);
		send_sample(12'sd2047, 12'sd2047, 1'b0);
		send_sample(12'sd1, 12'sd1, 1'b0);
		settle();

		// largest gain, weight past one, offsets that push both ends into saturation
		write_reg(CFG_UNMAPPED_6, $urandom, CFG_DATA_W);
		write_reg(CFG_UNMAPPED_7, $urandom, CFG_DATA_W);
		write_all(1048575, 131071, 4095, -4096, -32768, 0);
		send_sample(12'sd2047, -12'sd2048, 1'b0);
		send_sample(-12'sd2048, 12'sd2047, 1'b0);
		send_sample(12'sd0, 12'sd0, 1'b0);
		send_sample(-12'sd1, -12'sd1, 1'b0);
		settle();

		// zero gain and zero weight: filters hold, floor above every reading
		write_all(0, 0, 0, 0, 32767, 65535);
		send_sample(12'sd2047, -12'sd2048, 1'b1);
		send_sample(12'sd5, 12'sd5, 1'b0);
		settle();

		// unity gain, weight of exactly one
		write_all(65536, 65536, -4096, 4095, -2048, 4095);
		send_sample(-12'sd2048, 12'sd2047, 1'b0);
		send_sample(12'sd2047, -12'sd2048, 1'b0);
		send_sample(12'sd300, -12'sd300, 1'b1);
		settle();

		// smallest non-zero weight
		write_all(209715, 1, 0, 0, -160, 800);
		send_sample(12'sd2047, 12'sd2047, 1'b0);
		send_sample(-12'sd2048, -12'sd2048, 1'b0);
		send_sample(12'sd1000, 12'sd1000, 1'b1);
		send_sample(12'sd1001, 12'sd999, 1'b0);
		settle();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			idle_on = ($urandom_range(0, 3) != 0);
			// no idling on either side in the last part
			if (p == RANDOM_PHASES - 1)
				quiet = 1'b1;
			random_settings();
			random_phase(PHASE_SAMPLES);
			settle();
		end

		waited = 0;
		while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (20) @(posedge clk);
		sb.check_leftovers();

		$display("run covered %0d words (%0d with filter restart), %0d results checked",
			sb.n_samples, sb.n_restarts, sb.n_checked);
		$display("%0d results flagged a fault, %0d saturated; %0d register writes over %0d settings",
			sb.n_faults, sb.n_saturated, sb.n_writes, n_settings);
		if (sb.mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#2000000;
		$display("timeout: %0d results still outstanding", sb.pending());
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== dual_thermocouple_ema_monitor.f =====
+incdir+rtl
rtl/dtem_pkg.sv
rtl/dtem_lane.sv
rtl/dtem_merge.sv
rtl/dual_thermocouple_ema_monitor.sv
rtl/dtem_checker.sv
bench/tb_top.sv
